>>> design/audio_sample_convert_downmix_macros.svh
// assertion macros shared by the sample converter modules
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef AUDIO_SAMPLE_CONVERT_DOWNMIX_MACROS_SVH
`define AUDIO_SAMPLE_CONVERT_DOWNMIX_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define ASSERT_HOLDS(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error("assertion failed");
// condition at one edge implies consequence at the next edge
`define ASSERT_NEXT(label, clk_sig, rst_sig, cond, conseq) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (cond) |=> (conseq)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk_sig, rst_sig, prop)
`define ASSERT_NEXT(label, clk_sig, rst_sig, cond, conseq)
`endif

`endif

>>> design/ascd_pkg.sv
// shared types and constants of the sample converter and downmix block
// no dependencies; used by the controller, datapath and top level
package ascd_pkg;

    localparam int RAW_W        = 64;
    localparam int SMP_W        = 16;
    localparam int FMT_W        = 4;
    localparam int CNT_W        = 4;
    localparam int MAX_CHANNELS = 8;

    // sample format codes
    localparam logic [FMT_W-1:0] FMT_S8  = 4'd0;
    localparam logic [FMT_W-1:0] FMT_S16 = 4'd1;
    localparam logic [FMT_W-1:0] FMT_S24 = 4'd2;
    localparam logic [FMT_W-1:0] FMT_S32 = 4'd3;
    localparam logic [FMT_W-1:0] FMT_U8  = 4'd4;
    localparam logic [FMT_W-1:0] FMT_U16 = 4'd5;
    localparam logic [FMT_W-1:0] FMT_U24 = 4'd6;
    localparam logic [FMT_W-1:0] FMT_U32 = 4'd7;
    localparam logic [FMT_W-1:0] FMT_F32 = 4'd8;
    localparam logic [FMT_W-1:0] FMT_F64 = 4'd9;

    // register indexes (address bit 2)
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_RESET = 4'd1;

    // controller to datapath commands, one step per cycle while not waiting for input or output
    typedef struct packed {
        logic load;
        logic decode;
        logic tsub;
        logic shift;
        logic update;
        logic absv;
        logic quot;
        logic emit;
    } ascd_cmd_t;

    // datapath to controller status, valid during the update step
    typedef struct packed {
        logic last;
        logic direct;
    } ascd_stat_t;

endpackage

>>> design/audio_sample_convert_downmix.sv
// top level of the pcm sample converter with stereo downmix
// holds the register port; depends on ascd_pkg, ascd_controller, ascd_datapath
//
// input channel: one raw sample beat per channel of a frame (in_valid, in_stall,
//   raw_sample), right aligned in the configured format
// output channel: one beat per frame (out_valid, out_stall, left_sample,
//   right_sample); mono puts the sample on left and zero on right
// register port: apb-style, sample_format at 0x0, channel_count at 0x4; the
//   user writes only while idle (unenforced); a write drops any partial frame
// steps: each input beat walks decode, scale, rounding shift and update
//   steps of one shared datapath, and the next beat is only taken after
//   them; the final beat of a frame goes on to the emit step, a downmix
//   frame first through magnitude and divide-by-side-count steps, plus any
//   wait for the output register
// a stalled output beat holds in its register; the next frame's samples are
//   still taken, and the block only waits when a new result finds the
//   output register full
// reset: format s16, one channel, frame position and side sums cleared,
//   no output beat pending

module audio_sample_convert_downmix (
    input  logic                                clk,
    input  logic                                rst_n,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // sample input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ascd_pkg::RAW_W-1:0]          raw_sample,
    // frame output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ascd_pkg::SMP_W-1:0]   left_sample,
    output logic signed [ascd_pkg::SMP_W-1:0]   right_sample
);

    logic [ascd_pkg::FMT_W-1:0] format_reg, format_next;
    logic [ascd_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       cfg_wr;
    ascd_pkg::ascd_cmd_t        cmd;
    ascd_pkg::ascd_stat_t       stat;

    // no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        format_next = format_reg;
        count_next  = count_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                ascd_pkg::REG_FORMAT: format_next = pwdata[ascd_pkg::FMT_W-1:0];
                ascd_pkg::REG_COUNT:  count_next  = pwdata[ascd_pkg::CNT_W-1:0];
                default:              format_next = format_reg;
            endcase
        end
    end

    // read back of the stored register values
    always_comb
    begin
        case (paddr[2])
            ascd_pkg::REG_FORMAT: prdata = {28'd0, format_reg};
            ascd_pkg::REG_COUNT:  prdata = {28'd0, count_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= ascd_pkg::FMT_S16;
            count_reg  <= ascd_pkg::COUNT_RESET;
        end
        else
        begin
            format_reg <= format_next;
            count_reg  <= count_next;
        end
    end

    // step sequencer and output beat handshake
    ascd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // conversion, accumulation and the output register
    ascd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_clear     (cfg_wr),
        .sample_format (format_reg),
        .channel_count (count_reg),
        .raw_sample    (raw_sample),
        .left_sample   (left_sample),
        .right_sample  (right_sample)
    );

endmodule

>>> design/ascd_controller.sv
// sequencer of the sample converter: handshakes and per-item step order
// depends on ascd_pkg and the assertion macro header
`include "audio_sample_convert_downmix_macros.svh"

module ascd_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ascd_pkg::ascd_cmd_t   cmd,
    input  ascd_pkg::ascd_stat_t  stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TSUB,
        ST_SHIFT,
        ST_UPD,
        ST_ABS,
        ST_QUOT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.decode = 1'b1;
                state_next = ST_TSUB;
            end
            ST_TSUB:
            begin
                cmd.tsub   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                if (!stat.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.direct)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                cmd.absv   = 1'b1;
                state_next = ST_QUOT;
            end
            ST_QUOT:
            begin
                cmd.quot   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && out_stall) || cmd.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_HOLDS(a_emit_slot_free, clk, rst_n, !cmd.emit || !out_valid_reg || !out_stall)
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, state_reg == ST_CONV)
    `ASSERT_NEXT(a_partial_frame, clk, rst_n, state_reg == ST_UPD && !stat.last, !in_stall)

endmodule

>>> design/ascd_datapath.sv
// datapath of the sample converter: format decode, float scaling,
// frame accumulation, side division and output register; uses ascd_pkg
`include "audio_sample_convert_downmix_macros.svh"

module ascd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ascd_pkg::ascd_cmd_t                 cmd,
    output ascd_pkg::ascd_stat_t                stat,
    input  logic                                cfg_clear,
    input  logic [ascd_pkg::FMT_W-1:0]          sample_format,
    input  logic [ascd_pkg::CNT_W-1:0]          channel_count,
    input  logic [ascd_pkg::RAW_W-1:0]          raw_sample,
    output logic signed [ascd_pkg::SMP_W-1:0]   left_sample,
    output logic signed [ascd_pkg::SMP_W-1:0]   right_sample
);

    // 0xAAAB / 2^17 is an exact third for values below 2^17
    localparam logic [15:0] RECIP_THIRD = 16'hAAAB;
    localparam logic [15:0] SAT_POS     = 16'h7FFF;
    localparam logic [15:0] SAT_NEG     = 16'h8000;
    localparam logic [7:0]  S8_BIAS     = 8'h80;

    logic [63:0]        raw_reg, raw_next;
    logic [15:0]        iv_reg, iv_next;
    logic               float_reg, float_next;
    logic               neg_reg, neg_next;
    logic               nan_reg, nan_next;
    logic               inf_reg, inf_next;
    logic [52:0]        m_reg, m_next;
    logic signed [12:0] e_reg, e_next;
    logic [52:0]        t_reg, t_next;
    logic               sat_reg, sat_next;
    logic               zero_reg, zero_next;
    logic [5:0]         sh_reg, sh_next;
    logic [15:0]        v_reg, v_next;
    logic [2:0]         pos_reg, pos_next;
    logic [20:0]        left_acc_reg, left_acc_next;
    logic [20:0]        right_acc_reg, right_acc_next;
    logic [19:0]        mag_l_reg, mag_l_next;
    logic [19:0]        mag_r_reg, mag_r_next;
    logic               sign_l_reg, sign_l_next;
    logic               sign_r_reg, sign_r_next;
    logic [15:0]        q_l_reg, q_l_next;
    logic [15:0]        q_r_reg, q_r_next;
    logic [15:0]        left_out_reg, left_out_next;
    logic [15:0]        right_out_reg, right_out_next;

    logic [3:0]         n_eff;
    logic [3:0]         pos_ext;
    logic [2:0]         p;
    logic               last;
    logic               direct;
    logic [15:0]        iv;
    logic               f_float;
    logic               f_neg;
    logic               f_nan;
    logic               f_inf;
    logic [52:0]        f_m;
    logic signed [12:0] f_e;
    logic [53:0]        m_round;
    logic signed [12:0] sh_full;
    logic               sat_now;
    logic [52:0]        r_shift;
    logic [15:0]        fv;
    logic [20:0]        v_ext;
    logic [20:0]        v2_ext;
    logic [20:0]        left_abs;
    logic [20:0]        right_abs;
    logic [34:0]        prod_l;
    logic [34:0]        prod_r;
    logic [15:0]        q_l_div;
    logic [15:0]        q_r_div;

    // effective channel count, clamped to 1..MAX_CHANNELS
    always_comb
    begin
        if (channel_count == '0)
        begin
            n_eff = 4'd1;
        end
        else if (channel_count > ascd_pkg::CNT_W'(ascd_pkg::MAX_CHANNELS))
        begin
            n_eff = ascd_pkg::CNT_W'(ascd_pkg::MAX_CHANNELS);
        end
        else
        begin
            n_eff = channel_count;
        end
    end

    assign pos_ext     = {1'b0, pos_reg};
    assign p           = (pos_ext >= n_eff) ? 3'd0 : pos_reg;
    assign last        = ({1'b0, p} + 4'd1) == n_eff;
    assign direct      = n_eff <= 4'd2;
    assign stat        = '{last: last, direct: direct};

    // integer formats
    always_comb
    begin
        case (sample_format)
            ascd_pkg::FMT_S8:  iv = {8'h00, raw_reg[7:0] + S8_BIAS};
            ascd_pkg::FMT_S24: iv = raw_reg[23:8];
            ascd_pkg::FMT_S32: iv = raw_reg[31:16] + 16'(raw_reg[31] && (raw_reg[15:0] != '0));
            ascd_pkg::FMT_U8:  iv = {8'h00, raw_reg[7:0]};
            ascd_pkg::FMT_U16: iv = {~raw_reg[15], raw_reg[14:0]};
            ascd_pkg::FMT_U24: iv = {~raw_reg[23], raw_reg[22:8]};
            ascd_pkg::FMT_U32: iv = {~raw_reg[31], raw_reg[30:16]};
            default:           iv = raw_reg[15:0];
        endcase
    end

    // ieee single and double unpacking into a 53-bit mantissa
    always_comb
    begin
        f_float = 1'b0;
        f_neg   = raw_reg[31];
        f_nan   = 1'b0;
        f_inf   = 1'b0;
        f_m     = '0;
        f_e     = '0;
        case (sample_format)
            ascd_pkg::FMT_F32:
            begin
                f_float = 1'b1;
                f_neg   = raw_reg[31];
                f_nan   = (raw_reg[30:23] == 8'hFF) && (raw_reg[22:0] != '0);
                f_inf   = (raw_reg[30:23] == 8'hFF) && (raw_reg[22:0] == '0);
                f_m     = {(raw_reg[30:23] != '0), raw_reg[22:0], 29'd0};
                f_e     = (raw_reg[30:23] == '0) ? -13'sd126
                        : $signed({5'd0, raw_reg[30:23]}) - 13'sd127;
            end
            ascd_pkg::FMT_F64:
            begin
                f_float = 1'b1;
                f_neg   = raw_reg[63];
                f_nan   = (raw_reg[62:52] == 11'h7FF) && (raw_reg[51:0] != '0);
                f_inf   = (raw_reg[62:52] == 11'h7FF) && (raw_reg[51:0] == '0);
                f_m     = {(raw_reg[62:52] != '0), raw_reg[51:0]};
                f_e     = (raw_reg[62:52] == '0) ? -13'sd1022
                        : $signed({2'd0, raw_reg[62:52]}) - 13'sd1023;
            end
            default:
            begin
                f_float = 1'b0;
            end
        endcase
    end

    // m*32767/2^15 as m - ceil(m/2^15), then the exponent shift
    assign m_round = {1'b0, m_reg} + 54'd32767;
    assign sh_full = 13'sd37 - e_reg;
    assign sat_now = inf_reg || (e_reg >= 13'sd16);
    assign r_shift = t_reg >> sh_reg;

    always_comb
    begin
        if (zero_reg)
        begin
            fv = '0;
        end
        else if (sat_reg || (r_shift[52:15] != '0))
        begin
            fv = neg_reg ? SAT_NEG : SAT_POS;
        end
        else if (neg_reg)
        begin
            fv = 16'd0 - {1'b0, r_shift[14:0]};
        end
        else
        begin
            fv = {1'b0, r_shift[14:0]};
        end
    end

    assign v_ext  = {{5{v_reg[15]}}, v_reg};
    assign v2_ext = {{4{v_reg[15]}}, v_reg, 1'b0};

    assign left_abs  = left_acc_reg[20] ? (21'd0 - left_acc_reg) : left_acc_reg;
    assign right_abs = right_acc_reg[20] ? (21'd0 - right_acc_reg) : right_acc_reg;

    assign prod_l = 35'(mag_l_reg[19:1]) * 35'(RECIP_THIRD);
    assign prod_r = 35'(mag_r_reg[19:1]) * 35'(RECIP_THIRD);

    // side divisor is 4, 6 or 8 terms doubled
    always_comb
    begin
        if (n_eff <= 4'd4)
        begin
            q_l_div = mag_l_reg[17:2];
            q_r_div = mag_r_reg[17:2];
        end
        else if (n_eff <= 4'd6)
        begin
            q_l_div = prod_l[32:17];
            q_r_div = prod_r[32:17];
        end
        else
        begin
            q_l_div = mag_l_reg[18:3];
            q_r_div = mag_r_reg[18:3];
        end
    end

    always_comb
    begin
        raw_next       = raw_reg;
        iv_next        = iv_reg;
        float_next     = float_reg;
        neg_next       = neg_reg;
        nan_next       = nan_reg;
        inf_next       = inf_reg;
        m_next         = m_reg;
        e_next         = e_reg;
        t_next         = t_reg;
        sat_next       = sat_reg;
        zero_next      = zero_reg;
        sh_next        = sh_reg;
        v_next         = v_reg;
        pos_next       = pos_reg;
        left_acc_next  = left_acc_reg;
        right_acc_next = right_acc_reg;
        mag_l_next     = mag_l_reg;
        mag_r_next     = mag_r_reg;
        sign_l_next    = sign_l_reg;
        sign_r_next    = sign_r_reg;
        q_l_next       = q_l_reg;
        q_r_next       = q_r_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;

        if (cmd.load)
        begin
            raw_next = raw_sample;
        end
        if (cmd.decode)
        begin
            iv_next    = iv;
            float_next = f_float;
            neg_next   = f_neg;
            nan_next   = f_nan;
            inf_next   = f_inf;
            m_next     = f_m;
            e_next     = f_e;
        end
        if (cmd.tsub)
        begin
            t_next    = m_reg - {14'd0, m_round[53:15]};
            sat_next  = sat_now;
            zero_next = nan_reg || (!sat_now && (sh_full >= 13'sd64));
            sh_next   = sh_full[5:0];
        end
        if (cmd.shift)
        begin
            v_next = float_reg ? fv : iv_reg;
        end
        if (cmd.update)
        begin
            if (n_eff == 4'd1)
            begin
                q_l_next       = v_reg;
                q_r_next       = '0;
                sign_l_next    = 1'b0;
                sign_r_next    = 1'b0;
                pos_next       = '0;
                left_acc_next  = '0;
                right_acc_next = '0;
            end
            else if (n_eff == 4'd2)
            begin
                if (p == 3'd0)
                begin
                    left_acc_next = v_ext;
                    pos_next      = 3'd1;
                end
                else
                begin
                    q_l_next       = left_acc_reg[15:0];
                    q_r_next       = v_reg;
                    sign_l_next    = 1'b0;
                    sign_r_next    = 1'b0;
                    pos_next       = '0;
                    left_acc_next  = '0;
                    right_acc_next = '0;
                end
            end
            else
            begin
                // centre channel adds half to each side
                if ((p == 3'd0) && n_eff[0])
                begin
                    left_acc_next  = left_acc_reg + v_ext;
                    right_acc_next = right_acc_reg + v_ext;
                end
                else if (!p[0])
                begin
                    left_acc_next = left_acc_reg + v2_ext;
                end
                else
                begin
                    right_acc_next = right_acc_reg + v2_ext;
                end
                pos_next = last ? 3'd0 : p + 3'd1;
            end
        end
        if (cmd.absv)
        begin
            mag_l_next     = left_abs[19:0];
            mag_r_next     = right_abs[19:0];
            sign_l_next    = left_acc_reg[20];
            sign_r_next    = right_acc_reg[20];
            left_acc_next  = '0;
            right_acc_next = '0;
        end
        if (cmd.quot)
        begin
            q_l_next = q_l_div;
            q_r_next = q_r_div;
        end
        if (cmd.emit)
        begin
            left_out_next  = sign_l_reg ? (16'd0 - q_l_reg) : q_l_reg;
            right_out_next = sign_r_reg ? (16'd0 - q_r_reg) : q_r_reg;
        end
        if (cfg_clear)
        begin
            pos_next       = '0;
            left_acc_next  = '0;
            right_acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            left_acc_reg  <= left_acc_next;
            right_acc_reg <= right_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg       <= raw_next;
        iv_reg        <= iv_next;
        float_reg     <= float_next;
        neg_reg       <= neg_next;
        nan_reg       <= nan_next;
        inf_reg       <= inf_next;
        m_reg         <= m_next;
        e_reg         <= e_next;
        t_reg         <= t_next;
        sat_reg       <= sat_next;
        zero_reg      <= zero_next;
        sh_reg        <= sh_next;
        v_reg         <= v_next;
        mag_l_reg     <= mag_l_next;
        mag_r_reg     <= mag_r_next;
        sign_l_reg    <= sign_l_next;
        sign_r_reg    <= sign_r_next;
        q_l_reg       <= q_l_next;
        q_r_reg       <= q_r_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign left_sample  = $signed(left_out_reg);
    assign right_sample = $signed(right_out_reg);

    `ASSERT_HOLDS(a_pos_in_frame, clk, rst_n, pos_ext < n_eff)
    `ASSERT_NEXT(a_clear_empties, clk, rst_n, cfg_clear, pos_reg == '0 && left_acc_reg == '0)

endmodule

>>> verif/audio_sample_convert_downmix_tb.sv
// self-checking bench for the pcm sample converter with stereo downmix
// drives beats and register writes, predicts every output frame and compares it
// depends on ascd_pkg and audio_sample_convert_downmix
module audio_sample_convert_downmix_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // format and channel codes outside the documented range
    localparam logic [ascd_pkg::FMT_W-1:0] FMT_UNUSED   = 4'd12;
    localparam logic [ascd_pkg::FMT_W-1:0] FMT_TOP_CODE = 4'd15;
    localparam logic [ascd_pkg::CNT_W-1:0] COUNT_ZERO   = 4'd0;
    localparam logic [ascd_pkg::CNT_W-1:0] COUNT_TOP    = 4'd15;

    // an item may still be in the datapath after the last frame has left,
    // so wait a little longer
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASES_PER_MODE = 9;

    typedef struct packed {
        logic signed [ascd_pkg::SMP_W-1:0] left;
        logic signed [ascd_pkg::SMP_W-1:0] right;
    } frame_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    // one directed step: a register write or a sample beat, with the frame
    // typed in where it is obvious
    typedef struct packed {
        row_kind_t                  kind;
        logic                       reg_sel;
        logic [3:0]                 value;
        logic [ascd_pkg::RAW_W-1:0] raw;
        logic                       typed;
        frame_t                     want;
    } stim_row_t;

    localparam int N_DIRECTED = 40;
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // s16 mono straight after reset, both extremes, upper bits ignored
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h7FFF, 1'b1,
          '{16'sh7FFF, 16'sh0000}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'hFFFF_FFFF_FFFF_8000, 1'b1,
          '{16'sh8000, 16'sh0000}},
        // s8 offset wraps modulo 256
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_S8, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h00, 1'b1,
          '{16'sd128, 16'sh0000}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h7F, 1'b1,
          '{16'sd255, 16'sh0000}},
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_U8, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{16'sd255, 16'sh0000}},
        // 24-bit forms keep bits 23..8
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_S24, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h0080_0000, 1'b1,
          '{16'sh8000, 16'sh0000}},
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_U24, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h00FF_FFFF, 1'b1,
          '{16'sh7FFF, 16'sh0000}},
        // s32 divide truncates toward zero
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_S32, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'hFFFF_0001, 1'b1,
          '{16'sh0000, 16'sh0000}},
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_U16, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h0, 1'b1,
          '{16'sh8000, 16'sh0000}},
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_U32, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'hFFFF_FFFF, 1'b1,
          '{16'sh7FFF, 16'sh0000}},
        // single precision: one, one half, nan, minus infinity
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_F32, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h3F80_0000, 1'b1,
          '{16'sh7FFF, 16'sh0000}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h3F00_0000, 1'b1,
          '{16'sd16383, 16'sh0000}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h7FC0_0000, 1'b1,
          '{16'sh0000, 16'sh0000}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'hFF80_0000, 1'b1,
          '{16'sh8000, 16'sh0000}},
        // double: minus two saturates, nan gives zero
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_F64, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'hC000_0000_0000_0000, 1'b1,
          '{16'sh8000, 16'sh0000}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h7FF8_0000_0000_0001, 1'b1,
          '{16'sh0000, 16'sh0000}},
        // unknown format code behaves as s16
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, FMT_UNUSED, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'hABCD_0000_0000_1234, 1'b1,
          '{16'sh1234, 16'sh0000}},
        // stereo pair
        '{ROW_WRITE, ascd_pkg::REG_FORMAT, ascd_pkg::FMT_S16, 64'h0, 1'b0,
          '{16'sh0, 16'sh0}},
        '{ROW_WRITE, ascd_pkg::REG_COUNT, 4'd2, 64'h0, 1'b0, '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h0001, 1'b0, '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'hFFFF, 1'b1,
          '{16'sh0001, 16'shFFFF}},
        // three channels: channel 0 is a centre shared by both sides
        '{ROW_WRITE, ascd_pkg::REG_COUNT, 4'd3, 64'h0, 1'b0, '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'd100, 1'b0, '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'd200, 1'b0, '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'd300, 1'b1,
          '{16'sd175, 16'sd125}},
        // partial frame, dropped by the next register write
        '{ROW_WRITE, ascd_pkg::REG_COUNT, 4'd4, 64'h0, 1'b0, '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h7FFF, 1'b0, '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h8000, 1'b0, '{16'sh0, 16'sh0}},
        // zero channels means mono
        '{ROW_WRITE, ascd_pkg::REG_COUNT, COUNT_ZERO, 64'h0, 1'b0, '{16'sh0, 16'sh0}},
        '{ROW_SAMPLE, ascd_pkg::REG_FORMAT, 4'd0, 64'h5555, 1'b1,
          '{16'sh5555, 16'sh0000}}
    };

    // dut ports, all inputs known from time zero
    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [2:0]                        paddr = '0;
    logic [31:0]                       pwdata = '0;
    logic [31:0]                       prdata;
    logic                              pready;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [ascd_pkg::RAW_W-1:0]        raw_sample = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [ascd_pkg::SMP_W-1:0] left_sample;
    logic signed [ascd_pkg::SMP_W-1:0] right_sample;

    // predictor state: registers, frame position and doubled side sums
    logic [ascd_pkg::FMT_W-1:0] cfg_format = ascd_pkg::FMT_S16;
    logic [ascd_pkg::CNT_W-1:0] cfg_channels = ascd_pkg::COUNT_RESET;
    int                         frame_pos = 0;
    int                         left_sum = 0;
    int                         right_sum = 0;

    frame_t expected_frames[$];
    int     mismatches = 0;
    int     quiet_cycles = 0;

    // idling controls shared with the receiver process
    int src_idle_pct = 30;
    int dst_idle_pct = 71;
    int hold_request = 0;
    int hold_left = 0;

    audio_sample_convert_downmix dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_sample   (raw_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample)
    );

    always #5 clk = ~clk;

    // m * 2^(expo-52) times 32767, truncated toward zero and saturated
    function automatic int scale_float(input bit neg, input logic [63:0] mant,
                                       input int expo, input bit is_nan,
                                       input bit is_inf);
        logic [63:0] t;
        logic [63:0] r;
        int          sh;
        longint      v;
        if (is_nan)
            return 0;
        if (is_inf || expo >= 16)
            return neg ? -32768 : 32767;
        if (mant == 0)
            return 0;
        // floor(m * 32767 / 2^15) without overflow
        t = mant - ((mant + 64'd32767) >> 15);
        sh = 52 - expo - 15;
        r = (sh >= 64) ? 64'd0 : (t >> sh);
        v = neg ? -longint'(r) : longint'(r);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return int'(v);
    endfunction

    // converts one beat and advances the frame; returns 1 when a frame completes
    function automatic bit frame_step(input logic [ascd_pkg::RAW_W-1:0] raw,
                                      output frame_t res);
        int          v;
        int          n;
        int          pos;
        int          den;
        logic [7:0]  byte_sum;
        logic [7:0]  ef8;
        logic [22:0] frac23;
        logic [10:0] ef11;
        logic [51:0] frac52;
        res = '0;
        case (cfg_format)
            ascd_pkg::FMT_S8:
            begin
                byte_sum = raw[7:0] + 8'h80;
                v = int'(byte_sum);
            end
            ascd_pkg::FMT_S24: v = int'($signed(raw[23:8]));
            ascd_pkg::FMT_S32: v = int'($signed(raw[31:0])) / 65536;
            ascd_pkg::FMT_U8:  v = int'(raw[7:0]);
            ascd_pkg::FMT_U16: v = int'(raw[15:0]) - 32768;
            ascd_pkg::FMT_U24: v = int'(raw[23:8]) - 32768;
            ascd_pkg::FMT_U32: v = int'(raw[31:16]) - 32768;
            ascd_pkg::FMT_F32:
            begin
                ef8 = raw[30:23];
                frac23 = raw[22:0];
                if (ef8 == 8'hFF)
                    v = scale_float(raw[31], 64'd0, 0, frac23 != 0, frac23 == 0);
                else if (ef8 == 8'h00)
                    v = scale_float(raw[31], {41'd0, frac23} << 29, -126, 1'b0, 1'b0);
                else
                    v = scale_float(raw[31], {40'd0, 1'b1, frac23} << 29,
                                    int'(ef8) - 127, 1'b0, 1'b0);
            end
            ascd_pkg::FMT_F64:
            begin
                ef11 = raw[62:52];
                frac52 = raw[51:0];
                if (ef11 == 11'h7FF)
                    v = scale_float(raw[63], 64'd0, 0, frac52 != 0, frac52 == 0);
                else if (ef11 == 11'h000)
                    v = scale_float(raw[63], {12'd0, frac52}, -1022, 1'b0, 1'b0);
                else
                    v = scale_float(raw[63], {11'd0, 1'b1, frac52},
                                    int'(ef11) - 1023, 1'b0, 1'b0);
            end
            default: v = int'($signed(raw[15:0]));
        endcase

        n = int'(cfg_channels);
        if (n == 0)
            n = 1;
        if (n > ascd_pkg::MAX_CHANNELS)
            n = ascd_pkg::MAX_CHANNELS;
        pos = (frame_pos >= n) ? 0 : frame_pos;

        if (n == 1)
        begin
            frame_pos = 0;
            left_sum = 0;
            right_sum = 0;
            res.left = v[15:0];
            return 1'b1;
        end
        if (n == 2)
        begin
            if (pos == 0)
            begin
                left_sum = v;
                frame_pos = 1;
                return 1'b0;
            end
            res.left = left_sum[15:0];
            res.right = v[15:0];
            frame_pos = 0;
            left_sum = 0;
            right_sum = 0;
            return 1'b1;
        end

        // downmix: sums are doubled so the centre adds half to each side
        if (pos == 0 && n % 2 == 1)
        begin
            left_sum += v;
            right_sum += v;
        end
        else if (pos % 2 == 0)
            left_sum += 2 * v;
        else
            right_sum += 2 * v;
        if (pos + 1 < n)
        begin
            frame_pos = pos + 1;
            return 1'b0;
        end
        den = 2 * ((n + 1) / 2);
        res.left = 16'(left_sum / den);
        res.right = 16'(right_sum / den);
        frame_pos = 0;
        left_sum = 0;
        right_sum = 0;
        return 1'b1;
    endfunction

    // lower valid and wait until every frame is out and the datapath is quiet
    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write while idle: setup cycle, then access cycle; also clears the frame
    task automatic write_register(input logic reg_sel, input logic [3:0] value);
        drain_block();
        paddr <= {reg_sel, 2'b00};
        pwdata <= {28'd0, value};
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == ascd_pkg::REG_FORMAT)
            cfg_format = value;
        else
            cfg_channels = value;
        frame_pos = 0;
        left_sum = 0;
        right_sum = 0;
    endtask

    // offers one beat, waits for it to be taken, then queues the frame it completes
    task automatic feed_sample(input logic [ascd_pkg::RAW_W-1:0] raw, input logic typed,
                               input frame_t typed_frame);
        frame_t predicted;
        bit     produced;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_sample <= raw;
        do
            @(posedge clk);
        while (in_stall);
        produced = frame_step(raw, predicted);
        if (produced)
            expected_frames.push_back(typed ? typed_frame : predicted);
    endtask

    // receiver: random stall, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < dst_idle_pct);
    end

    // output checker: each accepted beat against the oldest queued frame
    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t unexpected output beat: expected none, got left %0d right %0d",
                         $time, left_sample, right_sample);
                mismatches++;
            end
            else
            begin
                want = expected_frames.pop_front();
                if (left_sample !== want.left)
                begin
                    $display("%0t left_sample mismatch: expected %0d, got %0d",
                             $time, want.left, left_sample);
                    mismatches++;
                end
                if (right_sample !== want.right)
                begin
                    $display("%0t right_sample mismatch: expected %0d, got %0d",
                             $time, want.right, right_sample);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any beat on either side ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no beat for %0d cycles, %0d frames outstanding",
                         $time, quiet_cycles, expected_frames.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t                  row;
        int                         mode;
        int                         ph;
        int                         frames;
        int                         n_items;
        int                         n_eff;
        int                         pick;
        logic [ascd_pkg::FMT_W-1:0] fmt;
        logic [ascd_pkg::CNT_W-1:0] cnt;
        logic [ascd_pkg::RAW_W-1:0] raw;

        // reset held low from time zero, released on a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: extremes, every format and the odd corners
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_WRITE)
                write_register(row.reg_sel, row.value);
            else
                feed_sample(row.raw, row.typed, row.want);
        end

        // random phases: sender busy / receiver busy, swapped, then no idling
        for (mode = 0; mode < 3; mode++)
        begin
            src_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 71 : 0;
            dst_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 30 : 0;
            for (ph = 0; ph < PHASES_PER_MODE; ph++)
            begin
                // walk all formats, now and then an undefined code
                fmt = 4'((mode * PHASES_PER_MODE + ph) % 10);
                if (ph == PHASES_PER_MODE - 1)
                    fmt = FMT_TOP_CODE;
                else if ($urandom_range(7) == 0)
                    fmt = 4'($urandom_range(10, 15));

                // mono, widest downmix and the over-range count first
                if (ph == 0)
                    cnt = 4'd1;
                else if (ph == 1)
                    cnt = 4'(ascd_pkg::MAX_CHANNELS);
                else if (ph == 2)
                    cnt = COUNT_TOP;
                else if ($urandom_range(7) == 0)
                    cnt = 4'($urandom_range(0, 15));
                else
                    cnt = 4'($urandom_range(1, ascd_pkg::MAX_CHANNELS));

                write_register(ascd_pkg::REG_FORMAT, fmt);
                write_register(ascd_pkg::REG_COUNT, cnt);

                n_eff = (cnt == 0) ? 1
                      : (cnt > ascd_pkg::MAX_CHANNELS) ? ascd_pkg::MAX_CHANNELS : int'(cnt);
                frames = $urandom_range(1, 4);
                // back-pressure: receiver holds off while mono beats keep coming,
                // so the output register fills and the input stalls
                if (mode == 2 && ph == 0)
                begin
                    frames = 12;
                    hold_request = HOLD_CYCLES;
                end
                n_items = frames * n_eff;
                // sometimes leave a partial frame for the next write to drop
                if (n_eff > 1 && $urandom_range(3) == 0)
                    n_items += $urandom_range(1, n_eff - 1);

                for (int k = 0; k < n_items; k++)
                begin
                    raw = {$urandom, $urandom};
                    pick = $urandom_range(15);
                    if (pick == 0)
                        raw = '0;
                    else if (pick == 1)
                        raw = '1;
                    else if (pick < 12)
                    begin
                        // keep most floats near full scale rather than tiny or huge
                        if (fmt == ascd_pkg::FMT_F32)
                            raw[30:23] = 8'($urandom_range(107, 143));
                        else if (fmt == ascd_pkg::FMT_F64)
                            raw[62:52] = 11'($urandom_range(1003, 1039));
                    end
                    feed_sample(raw, 1'b0, '0);
                end
            end
        end

        drain_block();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> audio_sample_convert_downmix.f
+incdir+design
design/ascd_pkg.sv
design/ascd_controller.sv
design/ascd_datapath.sv
design/audio_sample_convert_downmix.sv
verif/audio_sample_convert_downmix_tb.sv
